>>> sv/depth_pixel_to_point_core_assert.svh
// assertion macros for the depth pixel to point core
`ifndef DEPTH_PIXEL_TO_POINT_CORE_ASSERT_SVH
`define DEPTH_PIXEL_TO_POINT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define DP2P_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication
`define DP2P_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define DP2P_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DP2P_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/dp2p_pkg.sv
// package with widths and register codes of the depth pixel to point core
`timescale 1ns / 1ps
`default_nettype none
package dp2p_pkg;
   // pixel index width
   localparam int COORD_BITS = 12;
   // magnitude width of the q.4 offset from the principal point
   localparam int OFF_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
   // offset magnitude times z
   localparam int M_W = OFF_W + 32;
   // upper partial product
   localparam int A_W = OFF_W + 40;
   // rounded magnitude before saturation
   localparam int R_W = OFF_W + 29;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_PRINCIPAL_X   = 3'd0,
      REG_PRINCIPAL_Y   = 3'd1,
      REG_INV_FOCAL_X   = 3'd2,
      REG_INV_FOCAL_Y   = 3'd3,
      REG_INV_DEPTH_SCL = 3'd4
   } reg_index_type;
endpackage
`default_nettype wire

>>> sv/depth_pixel_to_point_core.sv
// top level of the pinhole depth pixel to point back-projection core
`timescale 1ns / 1ps
`default_nettype none
`include "depth_pixel_to_point_core_assert.svh"
// Back-projects one depth pixel per clock, while rsp_stall is low, through
// a pinhole camera model: z = depth / scale, x = (u - cx) * z / fx,
// y = (v - cy) * z / fy, all in Q16.16, with x and y saturated to the
// signed 32-bit range. The reciprocals 1/scale, 1/fx and 1/fy are programmed
// in Q0.32, the principal point in Q12.4. A pixel with zero depth or a zero
// mask byte is taken and dropped without a result. The datapath is a
// six-stage pipeline (depth product, z rounding, offset times z, split
// reciprocal product, partial sum, final add and saturation). Each stage
// holds its own valid bit and only stops when the stage in front of it is
// full and stopped, so bubbles are squeezed out and input is still taken
// while a finished result waits on rsp_stall, until the stages fill.
// Registers sit at byte addresses 0x00 principal_x, 0x04 principal_y,
// 0x08 inv_focal_x, 0x0c inv_focal_y, 0x10 inv_depth_scale, all reset to
// zero; they may only be written while no pixel is in flight.
module depth_pixel_to_point_core
   import dp2p_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel input
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [15:0]           req_depth_value,
   input  wire logic [7:0]            req_mask_value,
   input  wire logic [COORD_BITS-1:0] req_column,
   input  wire logic [COORD_BITS-1:0] req_row,
   // point output
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [31:0]         rsp_point_x,
   output logic signed [31:0]         rsp_point_y,
   output logic [31:0]                rsp_point_z,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   localparam int STAGES = 6;

   // ---------------------------------------------------------------- registers
   logic [15:0] principal_x_ff;
   logic [15:0] principal_y_ff;
   logic [31:0] inv_focal_x_ff;
   logic [31:0] inv_focal_y_ff;
   logic [31:0] inv_depth_scale_ff;
   reg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         principal_x_ff     <= '0;
         principal_y_ff     <= '0;
         inv_focal_x_ff     <= '0;
         inv_focal_y_ff     <= '0;
         inv_depth_scale_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PRINCIPAL_X:   principal_x_ff     <= pwdata[15:0];
            REG_PRINCIPAL_Y:   principal_y_ff     <= pwdata[15:0];
            REG_INV_FOCAL_X:   inv_focal_x_ff     <= pwdata;
            REG_INV_FOCAL_Y:   inv_focal_y_ff     <= pwdata;
            REG_INV_DEPTH_SCL: inv_depth_scale_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PRINCIPAL_X:   prdata = {16'b0, principal_x_ff};
         REG_PRINCIPAL_Y:   prdata = {16'b0, principal_y_ff};
         REG_INV_FOCAL_X:   prdata = inv_focal_x_ff;
         REG_INV_FOCAL_Y:   prdata = inv_focal_y_ff;
         REG_INV_DEPTH_SCL: prdata = inv_depth_scale_ff;
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   // a stage loads when it is empty or when the stage ahead loads
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;
   logic              pixel_live;

   assign pixel_live = (req_depth_value != 16'd0) && (req_mask_value != 8'd0);

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? (req_valid && pixel_live) : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------------------------------------------------------- stage 1
   // raw depth product and offsets from the principal point, lane 0 is x, lane 1 is y
   logic [47:0]      s1_zq_in;
   logic [OFF_W:0]   s1_diff [2];
   logic [1:0]       s1_neg_in;
   logic [OFF_W-1:0] s1_mag_in [2];
   logic [47:0]      s1_zq_ff;
   logic [1:0]       s1_neg_ff;
   logic [OFF_W-1:0] s1_mag_ff [2];

   assign s1_zq_in = {32'b0, req_depth_value} * {16'b0, inv_depth_scale_ff};

   always_comb begin
      s1_diff[0] = (OFF_W+1)'({req_column, 4'b0}) - (OFF_W+1)'(principal_x_ff);
      s1_diff[1] = (OFF_W+1)'({req_row, 4'b0}) - (OFF_W+1)'(principal_y_ff);
      for (int l = 0; l < 2; l++) begin
         s1_neg_in[l] = s1_diff[l][OFF_W];
         s1_mag_in[l] = s1_neg_in[l] ? OFF_W'(-s1_diff[l]) : s1_diff[l][OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_zq_ff  <= s1_zq_in;
         s1_neg_ff <= s1_neg_in;
         s1_mag_ff <= s1_mag_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // round z to q16.16, half up
   logic [47:0]      s2_sum;
   logic [31:0]      s2_z_ff;
   logic [1:0]       s2_neg_ff;
   logic [OFF_W-1:0] s2_mag_ff [2];

   assign s2_sum = s1_zq_ff + 48'h8000;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_z_ff   <= s2_sum[47:16];
         s2_neg_ff <= s1_neg_ff;
         s2_mag_ff <= s1_mag_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // offset magnitude times z
   logic [M_W-1:0] s3_m_ff [2];
   logic [31:0]    s3_z_ff;
   logic [1:0]     s3_neg_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         for (int l = 0; l < 2; l++) begin
            s3_m_ff[l] <= M_W'(s2_mag_ff[l]) * M_W'(s2_z_ff);
         end
         s3_z_ff   <= s2_z_ff;
         s3_neg_ff <= s2_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // product with the focal reciprocal, split at bit 24 into two partial products
   logic [31:0]    s4_recip [2];
   logic [A_W-1:0] s4_a_ff [2];
   logic [55:0]    s4_b_ff [2];
   logic [31:0]    s4_z_ff;
   logic [1:0]     s4_neg_ff;

   assign s4_recip[0] = inv_focal_x_ff;
   assign s4_recip[1] = inv_focal_y_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         for (int l = 0; l < 2; l++) begin
            s4_a_ff[l] <= A_W'(s3_m_ff[l][M_W-1:24]) * A_W'(s4_recip[l]);
            s4_b_ff[l] <= 56'(s3_m_ff[l][23:0]) * 56'(s4_recip[l]);
         end
         s4_z_ff   <= s3_z_ff;
         s4_neg_ff <= s3_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // low part of the sum with the rounding half, keep its carry into bit 36
   logic [56:0]     s5_low [2];
   logic [A_W-13:0] s5_hi_ff [2];
   logic [20:0]     s5_carry_ff [2];
   logic [31:0]     s5_z_ff;
   logic [1:0]      s5_neg_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s5_low[l] = 57'({s4_a_ff[l][11:0], 24'b0}) + 57'(s4_b_ff[l])
                   + (57'(1) << 35);
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         for (int l = 0; l < 2; l++) begin
            s5_hi_ff[l]    <= s4_a_ff[l][A_W-1:12];
            s5_carry_ff[l] <= s5_low[l][56:36];
         end
         s5_z_ff   <= s4_z_ff;
         s5_neg_ff <= s4_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   // final magnitude, sign and saturation into the output register
   logic [R_W-1:0] s6_r [2];
   logic [31:0]    s6_coord [2];
   logic           s6_big [2];
   logic [31:0]    x_ff;
   logic [31:0]    y_ff;
   logic [31:0]    z_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s6_r[l]   = R_W'(s5_hi_ff[l]) + R_W'(s5_carry_ff[l]);
         s6_big[l] = s6_r[l][R_W-1:31] != '0;
         if (s5_neg_ff[l]) begin
            s6_coord[l] = s6_big[l] ? 32'h8000_0000 : (32'd0 - s6_r[l][31:0]);
         end else begin
            s6_coord[l] = s6_big[l] ? 32'h7fff_ffff : s6_r[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         x_ff <= s6_coord[0];
         y_ff <= s6_coord[1];
         z_ff <= s5_z_ff;
      end
   end

   assign rsp_point_x = x_ff;
   assign rsp_point_y = y_ff;
   assign rsp_point_z = z_ff;

   // ---------------------------------------------------------------- checks
   // a point at zero depth lies on the optical centre
   `DP2P_ASSERT_IMPLY(zero_depth_on_axis, clock, reset,
      rsp_valid && (rsp_point_z == 32'd0), (rsp_point_x == 32'sd0) && (rsp_point_y == 32'sd0))
   // input only waits behind a full first stage
   `DP2P_ASSERT_IMPLY(stall_needs_full_entry, clock, reset, req_stall, valid_ff[0])
   // a live pixel taken in always occupies the first stage next cycle
   `DP2P_ASSERT_NEXT(live_pixel_enters, clock, reset,
      req_valid && !req_stall && pixel_live, valid_ff[0])
endmodule
`default_nettype wire
